[src/rddt_pkg.sv]
// Package for the relay delay/duration timer.
// Holds the action and register codes, the relay entry structs and the
// constants of the millisecond-to-second conversion. Depends on nothing.
package rddt_pkg;

  // Input action codes
  typedef enum logic [1:0] {
    ActTick     = 2'd0,
    ActSet      = 2'd1,
    ActResetAll = 2'd2
  } action_e;

  // Configuration register indexes
  localparam logic CfgOnLevel    = 1'b0;
  localparam logic CfgRelayCount = 1'b1;

  // Sequencer states
  typedef enum logic [2:0] {
    StIdle,
    StCalc,
    StDivT,
    StDivD,
    StEmit,
    StReply
  } state_e;

  localparam int unsigned MaskW    = 16;
  localparam int unsigned CountW   = 5;
  localparam int unsigned SecW     = 23;
  localparam int unsigned MsPerS   = 1000;
  // x / 1000 == (x * ceil(2^38 / 1000)) >> 38 for every 32-bit x
  localparam int unsigned DivShift = 38;
  localparam int unsigned MagicW   = 29;
  localparam logic [MagicW-1:0] DivMagic =
    MagicW'(((64'd1 << DivShift) + 64'(MsPerS) - 64'd1) / 64'(MsPerS));
  localparam int unsigned ProdW    = 32 + MagicW;

  // Raw output level after reset: off while on_level resets to zero
  localparam logic LevelReset = 1'b1;

  // One relay's stored timing state
  typedef struct packed {
    logic        level;
    logic        pend;
    logic [31:0] dur;
    logic [31:0] dly;
    logic [31:0] stamp;
  } rddt_entry_t;

  // Write of one entry
  typedef struct packed {
    logic        en;
    logic [3:0]  idx;
    rddt_entry_t data;
  } rddt_wr_t;

  // Drive every relay below a count off
  typedef struct packed {
    logic              en;
    logic [CountW-1:0] n;
    logic              level;
    logic [31:0]       stamp;
  } rddt_clr_t;

  // Raw level for a logical state
  function automatic logic level_of(input logic on, input logic on_level);
    return on ? on_level : ~on_level;
  endfunction

endpackage

[src/rddt_div1000.sv]
// Shared divide-by-1000 unit: reciprocal multiply with a registered quotient.
// Used twice per relay by the sequencer. Depends on rddt_pkg.
module rddt_div1000
  import rddt_pkg::*;
(
  input  logic            clk_i,
  input  logic            en_i,
  input  logic [31:0]     x_i,
  output logic [SecW-1:0] q_o
);

  logic [ProdW-1:0] prod;
  logic [SecW-1:0]  q_q;

  // Multiply by the reciprocal; the quotient is the upper bits
  assign prod = ProdW'(x_i) * ProdW'(DivMagic);

  // Hold the quotient until the next use
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      q_q <= prod[DivShift +: SecW];
    end
  end

  assign q_o = q_q;

endmodule

[src/rddt_bank.sv]
// Per-relay state registers with one read port, one entry write port and
// a drive-all-off port. Depends on rddt_pkg.
module rddt_bank
  import rddt_pkg::*;
#(
  parameter int unsigned NREL = 16,
  parameter int unsigned IW   = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [IW-1:0] rd_idx_i,
  output rddt_entry_t rd_o,
  input  rddt_wr_t    wr_i,
  input  rddt_clr_t   clr_i
);

  rddt_entry_t ent_q [NREL];

  // Update each entry: single write or drive-all-off
  for (genvar g = 0; g < NREL; g++) begin : g_ent
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        ent_q[g] <= '{level: LevelReset, pend: 1'b0, dur: '0, dly: '0, stamp: '0};
      end else if (clr_i.en && (CountW'(g) < clr_i.n)) begin
        ent_q[g] <= '{level: clr_i.level, pend: 1'b0, dur: '0, dly: '0,
                      stamp: clr_i.stamp};
      end else if (wr_i.en && (wr_i.idx[IW-1:0] == IW'(g))) begin
        ent_q[g] <= wr_i.data;
      end
    end
  end

  assign rd_o = ent_q[rd_idx_i];

endmodule

[src/relay_delay_duration_timer.sv]
// Relay delay/duration timer, top level: sequencer, config and output word.
// A tick walks relays 0..n-1; per relay an update state, two passes through
// the shared divide-by-1000 unit and an emit state that waits while the
// output is stalled. Set and reset-all answer with one reply word.
// Ready is high only while idle. Async active-low reset drives all relays off
// (on_level 0, relay_count 0) and clears the clock and reported mask.
module relay_delay_duration_timer
  import rddt_pkg::*;
#(
  parameter int unsigned MAX_RELAYS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration
  input  logic        cfg_we_i,
  input  logic [0:0]  cfg_addr_i,
  input  logic [4:0]  cfg_wdata_i,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [3:0] relay_id, [4] turn_on, [36:5] duration_ms, [68:37] start_wait_ms, zero pad
  input  logic [71:0] s_axis_tdata,
  // [1:0] action
  input  logic [1:0]  s_axis_tuser,
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [3:0] report_relay, [26:4] time_left_s, [49:27] delay_left_s,
  // [65:50] level_mask, [66] notify, zero pad
  output logic [71:0] m_axis_tdata,
  // [0] status
  output logic [0:0]  m_axis_tuser,
  output logic        m_axis_tlast
);

  localparam int unsigned NREL = (MAX_RELAYS < 16) ? MAX_RELAYS : 16;
  localparam int unsigned IW   = (NREL > 1) ? $clog2(NREL) : 1;

  // Unpack the input word
  logic [3:0]  in_id;
  logic        in_on;
  logic [31:0] in_dur;
  logic [31:0] in_dly;
  action_e     in_act;
  assign in_id  = s_axis_tdata[3:0];
  assign in_on  = s_axis_tdata[4];
  assign in_dur = s_axis_tdata[36:5];
  assign in_dly = s_axis_tdata[68:37];
  assign in_act = action_e'(s_axis_tuser);

  // Configuration registers
  logic              on_level_q;
  logic [CountW-1:0] relay_count_q;
  logic [CountW-1:0] n_use;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      on_level_q    <= 1'b0;
      relay_count_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        CfgOnLevel:    on_level_q    <= cfg_wdata_i[0];
        CfgRelayCount: relay_count_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign n_use = (relay_count_q > CountW'(NREL)) ? CountW'(NREL) : relay_count_q;

  // Sequencer and datapath registers
  state_e            state_q, state_d;
  logic [IW-1:0]     idx_q;
  logic [31:0]       clock_q;
  logic [MaskW-1:0]  mask_q;
  logic              notify_q;
  logic [MaskW-1:0]  reported_q;
  logic [31:0]       tl_ms_q, dl_ms_q;
  logic [SecW-1:0]   tl_s_q;
  logic              reply_status_q;

  logic              accept;
  logic              out_free;
  logic              load_out;
  logic              set_ok;
  logic              is_last;

  rddt_entry_t       rd;
  rddt_wr_t          wr;
  rddt_clr_t         clr;
  logic [IW-1:0]     rd_idx;

  logic              div_en;
  logic [31:0]       div_x;
  logic [SecW-1:0]   div_q;

  assign s_axis_tready = (state_q == StIdle);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign set_ok        = CountW'(in_id) < n_use;
  assign is_last       = (CountW'(idx_q) + CountW'(1)) == n_use;
  assign rd_idx        = (state_q == StIdle) ? in_id[IW-1:0] : idx_q;

  // Relay update for the current walk position
  logic        use_dly;
  logic        active;
  logic [31:0] stored;
  logic [31:0] elapsed;
  logic [31:0] rem;
  logic        expire;
  logic [31:0] tl_ms, dl_ms;
  rddt_entry_t upd;

  always_comb begin
    use_dly = rd.dly != '0;
    active  = use_dly || (rd.dur != '0);
    stored  = use_dly ? rd.dly : rd.dur;
    elapsed = clock_q - rd.stamp;
    rem     = (elapsed >= stored) ? '0 : stored - elapsed;
    expire  = active && (rem == '0);
    tl_ms   = (active && !use_dly) ? rem : rd.dur;
    dl_ms   = use_dly ? rem : rd.dly;
    if (use_dly) begin
      upd = '{level: level_of(rd.pend, on_level_q), pend: rd.pend, dur: rd.dur,
              dly: '0, stamp: clock_q};
    end else begin
      upd = '{level: level_of(~rd.pend, on_level_q), pend: ~rd.pend, dur: '0,
              dly: '0, stamp: clock_q};
    end
  end

  // Bank writes: set command at accept, expiry during the walk, drive-all-off at a reset-all accept
  always_comb begin
    wr  = '0;
    clr = '0;
    if (accept && (in_act == ActSet) && set_ok) begin
      wr.en         = 1'b1;
      wr.idx        = in_id;
      wr.data.level = (in_dly == '0) ? level_of(in_on, on_level_q) : rd.level;
      wr.data.pend  = in_on;
      wr.data.dur   = in_dur;
      wr.data.dly   = in_dly;
      wr.data.stamp = clock_q;
    end else if ((state_q == StCalc) && expire) begin
      wr.en   = 1'b1;
      wr.idx  = 4'(idx_q);
      wr.data = upd;
    end
    if (accept && (in_act == ActResetAll)) begin
      clr.en    = 1'b1;
      clr.n     = n_use;
      clr.level = ~on_level_q;
      clr.stamp = clock_q;
    end
  end

  rddt_bank #(
    .NREL (NREL),
    .IW   (IW)
  ) u_bank (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .rd_idx_i (rd_idx),
    .rd_o     (rd),
    .wr_i     (wr),
    .clr_i    (clr)
  );

  // Shared divider: duration first, then delay
  assign div_en = (state_q == StDivT) || (state_q == StDivD);
  assign div_x  = (state_q == StDivT) ? tl_ms_q : dl_ms_q;

  rddt_div1000 u_div (
    .clk_i (clk_i),
    .en_i  (div_en),
    .x_i   (div_x),
    .q_o   (div_q)
  );

  // Next state
  always_comb begin
    state_d  = state_q;
    load_out = 1'b0;
    case (state_q)
      StIdle: begin
        if (accept) begin
          case (in_act)
            ActTick:     state_d = (n_use == '0) ? StIdle : StCalc;
            ActSet:      state_d = StReply;
            ActResetAll: state_d = StReply;
            default:     state_d = StIdle;
          endcase
        end
      end
      StCalc: state_d = StDivT;
      StDivT: state_d = StDivD;
      StDivD: state_d = StEmit;
      StEmit: begin
        if (out_free) begin
          load_out = 1'b1;
          state_d  = is_last ? StIdle : StCalc;
        end
      end
      StReply: begin
        if (out_free) begin
          load_out = 1'b1;
          state_d  = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  // Walk index, clock, mask and notify tracking
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q          <= '0;
      clock_q        <= '0;
      mask_q         <= '0;
      notify_q       <= 1'b0;
      reported_q     <= '0;
      reply_status_q <= 1'b0;
    end else begin
      if (accept) begin
        idx_q          <= '0;
        mask_q         <= '0;
        notify_q       <= 1'b0;
        reply_status_q <= (in_act == ActSet) && !set_ok;
        if (in_act == ActTick) begin
          clock_q <= clock_q + 32'd1;
          // no relays in use: the mask seen is empty
          if (n_use == '0) begin
            reported_q <= '0;
          end
        end
      end
      if (state_q == StCalc) begin
        if (rd.level == on_level_q) begin
          mask_q <= mask_q | (MaskW'(1) << idx_q);
        end
        if (active) begin
          notify_q <= 1'b1;
        end
      end
      if ((state_q == StEmit) && load_out) begin
        if (is_last) begin
          reported_q <= mask_q;
        end else begin
          idx_q <= idx_q + IW'(1);
        end
      end
    end
  end

  // Per-relay millisecond values and first quotient
  always_ff @(posedge clk_i) begin
    if (state_q == StCalc) begin
      tl_ms_q <= tl_ms;
      dl_ms_q <= dl_ms;
    end
    if (state_q == StDivD) begin
      tl_s_q <= div_q;
    end
  end

  // Output word register
  logic        m_valid_q;
  logic [71:0] m_data_q;
  logic        m_status_q;
  logic        m_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (load_out) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      if (state_q == StEmit) begin
        m_data_q[3:0]   <= 4'(idx_q);
        m_data_q[26:4]  <= tl_s_q;
        m_data_q[49:27] <= div_q;
        m_data_q[65:50] <= is_last ? mask_q : '0;
        m_data_q[66]    <= is_last && (notify_q || (mask_q != reported_q));
        m_data_q[71:67] <= '0;
        m_status_q      <= 1'b0;
        m_last_q        <= is_last;
      end else begin
        m_data_q   <= '0;
        m_status_q <= reply_status_q;
        m_last_q   <= 1'b1;
      end
    end
  end

  assign m_axis_tvalid   = m_valid_q;
  assign m_axis_tdata    = m_data_q;
  assign m_axis_tuser[0] = m_status_q;
  assign m_axis_tlast    = m_last_q;

  // Mask and notify only travel on the last word of a run
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tlast) |-> (m_axis_tdata[66:50] == '0))
    else $error("mask or notify on a non-last word");

  // A rejected set gives a single all-zero last word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser[0]) |-> (m_axis_tlast && (m_axis_tdata == '0)))
    else $error("rejected set word malformed");

  // The walk never visits a relay beyond the count in use
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StCalc) |-> (CountW'(idx_q) < n_use))
    else $error("walk index out of range");

  // A word is only loaded when the output register is free
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_out |-> out_free)
    else $error("output word overwritten");

  // Bank writes never collide with a drive-all-off
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(wr.en && clr.en))
    else $error("entry write during reset-all");

endmodule
